// File: rtl/mcdq_pkg.sv
// Shared types, constants and register indexes of the click and drag qualifier.
`default_nettype none

package mcdq_pkg;

  localparam int BUTTONS_DEF    = 5;
  localparam int COORD_BITS_DEF = 16;

  localparam int TIME_W   = 32;
  localparam int TICK_W   = 16;
  localparam int WHEEL_W  = 8;
  localparam int SCROLL_W = 16;
  localparam int WINDOW_W = 16;
  localparam int DRAG_W   = 12;
  localparam int THR_W    = 2 * DRAG_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(500);
  localparam int                  DRAG_RESET   = 4;
  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(DRAG_RESET * DRAG_RESET);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DRAG   = CFG_IDX_W'(1);

  // Request kinds.
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_WHEEL = 1'b1;

  typedef struct packed {
    logic [WINDOW_W-1:0] window;
    logic [THR_W-1:0]    thr2;
  } cfg_t;

  typedef struct packed {
    logic down;
    logic up;
    logic dbl;
    logic drag;
  } lane_stat_t;

endpackage

`default_nettype wire

// File: rtl/mcdq_if.sv
// Channel interfaces: request, result and configuration write.
`default_nettype none

interface mcdq_req_if #(
  parameter int BUTTONS    = mcdq_pkg::BUTTONS_DEF,
  parameter int COORD_BITS = mcdq_pkg::COORD_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [BUTTONS-1:0]                   button_mask;
  logic signed [COORD_BITS-1:0]         pos_x;
  logic signed [COORD_BITS-1:0]         pos_y;
  logic [mcdq_pkg::TICK_W-1:0]          frame_ticks;
  logic signed [mcdq_pkg::WHEEL_W-1:0]  wheel_x;
  logic signed [mcdq_pkg::WHEEL_W-1:0]  wheel_y;

  modport source (output valid, req_type, button_mask, pos_x, pos_y, frame_ticks,
                  wheel_x, wheel_y, input ready);
  modport sink (input valid, req_type, button_mask, pos_x, pos_y, frame_ticks,
                wheel_x, wheel_y, output ready);
endinterface

interface mcdq_rsp_if #(
  parameter int BUTTONS    = mcdq_pkg::BUTTONS_DEF,
  parameter int COORD_BITS = mcdq_pkg::COORD_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic [BUTTONS-1:0]                    pressed_mask;
  logic [BUTTONS-1:0]                    down_mask;
  logic [BUTTONS-1:0]                    up_mask;
  logic [BUTTONS-1:0]                    double_mask;
  logic [BUTTONS-1:0]                    drag_mask;
  logic signed [COORD_BITS:0]            delta_x;
  logic signed [COORD_BITS:0]            delta_y;
  logic signed [mcdq_pkg::SCROLL_W-1:0]  scroll_x;
  logic signed [mcdq_pkg::SCROLL_W-1:0]  scroll_y;

  modport source (output valid, pressed_mask, down_mask, up_mask, double_mask, drag_mask,
                  delta_x, delta_y, scroll_x, scroll_y, input ready);
  modport sink (input valid, pressed_mask, down_mask, up_mask, double_mask, drag_mask,
                delta_x, delta_y, scroll_x, scroll_y, output ready);
endinterface

interface mcdq_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mcdq_pkg::CFG_IDX_W-1:0]     index;
  logic [mcdq_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/mcdq_cfg.sv
// Configuration registers: double click window and squared drag threshold.
`default_nettype none

module mcdq_cfg (
  input  wire logic     clk,
  input  wire logic     rst,
  mcdq_cfg_if.sink      cfg,
  output mcdq_pkg::cfg_t regs
);
  import mcdq_pkg::*;

  logic [THR_W-1:0] drag_len;

  assign cfg.ready = 1'b1;
  assign drag_len  = THR_W'(cfg.data[DRAG_W-1:0]);

  // The drag distance is only ever used squared, so the square is kept instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.window <= WINDOW_RESET;
      regs.thr2   <= THR_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_WINDOW) begin
        regs.window <= cfg.data[WINDOW_W-1:0];
      end else if (cfg.index == REG_DRAG) begin
        regs.thr2 <= drag_len * drag_len;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mcdq_lane.sv
// One button: edge detection, double click timing and drag qualification.
`default_nettype none

module mcdq_lane #(
  parameter int COORD_BITS = mcdq_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            fire,
  input  wire logic                            btn,
  input  wire logic [mcdq_pkg::TIME_W-1:0]     time_next,
  input  wire logic signed [COORD_BITS-1:0]    px,
  input  wire logic signed [COORD_BITS-1:0]    py,
  input  wire mcdq_pkg::cfg_t                  regs,
  output mcdq_pkg::lane_stat_t                 stat
);
  import mcdq_pkg::*;

  localparam int SQ_W  = 2 * (COORD_BITS + 1);
  localparam int D2_W  = SQ_W + 1;
  localparam int CMP_W = (D2_W > THR_W) ? D2_W : THR_W;

  logic                     prev;
  logic                     drag;
  logic                     armed;
  logic [TIME_W-1:0]        last_time;
  logic [COORD_BITS-1:0]    down_x;
  logic [COORD_BITS-1:0]    down_y;

  logic                     down;
  logic                     up;
  logic                     dbl;
  logic [TIME_W-1:0]        since;
  logic signed [COORD_BITS:0] ex;
  logic signed [COORD_BITS:0] ey;
  logic signed [SQ_W-1:0]   sqx;
  logic signed [SQ_W-1:0]   sqy;
  logic [D2_W-1:0]          d2;
  logic                     far;
  logic                     drag_next;

  assign down  = btn & ~prev;
  assign up    = ~btn & prev;
  assign since = time_next - last_time;
  assign dbl   = down & armed & (since <= TIME_W'(regs.window));

  // On a down edge the stored position is the current one, so the distance is zero.
  assign ex  = down ? '0 : ($signed({px[COORD_BITS-1], px}) -
                            $signed({down_x[COORD_BITS-1], down_x}));
  assign ey  = down ? '0 : ($signed({py[COORD_BITS-1], py}) -
                            $signed({down_y[COORD_BITS-1], down_y}));
  assign sqx = ex * ex;
  assign sqy = ey * ey;
  assign d2  = {1'b0, sqx} + {1'b0, sqy};
  assign far = CMP_W'(d2) >= CMP_W'(regs.thr2);

  always_comb begin
    if (btn) begin
      drag_next = drag | far;
    end else if (up) begin
      drag_next = 1'b0;
    end else begin
      drag_next = drag;
    end
  end

  assign stat.down = down;
  assign stat.up   = up;
  assign stat.dbl  = dbl;
  assign stat.drag = drag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= 1'b0;
      drag  <= 1'b0;
      armed <= 1'b0;
    end else if (fire) begin
      prev <= btn;
      drag <= drag_next;
      if (down) begin
        armed <= ~dbl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && down) begin
      down_x <= px;
      down_y <= py;
      if (!dbl) begin
        last_time <= time_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mouse_click_drag_qualifier_unit.sv
// Top level of the mouse click and drag qualifier.
//
// Requests enter on req (valid/ready). A frame request carries the button
// mask, pointer position and elapsed ticks; a wheel request carries wheel
// steps, adds them to saturating scroll accumulators and gives no result.
// Each frame request gives one result on rsp: held, down-edge, up-edge,
// double click and drag masks, pointer delta and the gathered scroll.
// Registers are written on cfg (always ready); the user is to write them only
// while the block is idle, which the block itself does not enforce. A request
// is held in the input register and worked on there, all buttons in parallel
// lanes; its result is registered in the output register, which drives
// rsp.valid. One request per cycle is taken when rsp is not stalled.
// When rsp stalls, a frame request waits in the input register and req
// drops ready; wheel requests still pass if the input stage is free.
// Reset (synchronous) clears all tracking state, empties both registers and
// restores a window of 500 ticks and a drag distance of 4 pixels.
`default_nettype none

module mouse_click_drag_qualifier_unit #(
  parameter int BUTTONS    = mcdq_pkg::BUTTONS_DEF,
  parameter int COORD_BITS = mcdq_pkg::COORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mcdq_req_if.sink   req,
  mcdq_rsp_if.source rsp,
  mcdq_cfg_if.sink   cfg
);
  import mcdq_pkg::*;

  function automatic logic [SCROLL_W-1:0] sat_add(input logic [SCROLL_W-1:0] acc,
                                                  input logic [WHEEL_W-1:0] step);
    logic [SCROLL_W:0] sum;
    logic [SCROLL_W-1:0] res;
    sum = {acc[SCROLL_W-1], acc} + {{(SCROLL_W + 1 - WHEEL_W){step[WHEEL_W-1]}}, step};
    if (sum[SCROLL_W] != sum[SCROLL_W-1]) begin
      res = sum[SCROLL_W] ? {1'b1, {(SCROLL_W - 1){1'b0}}} : {1'b0, {(SCROLL_W - 1){1'b1}}};
    end else begin
      res = sum[SCROLL_W-1:0];
    end
    return res;
  endfunction

  cfg_t regs;

  // Input register.
  logic                     s_valid;
  logic                     s_type;
  logic [BUTTONS-1:0]       s_btn;
  logic signed [COORD_BITS-1:0] s_px;
  logic signed [COORD_BITS-1:0] s_py;
  logic [TICK_W-1:0]        s_ticks;
  logic [WHEEL_W-1:0]       s_wx;
  logic [WHEEL_W-1:0]       s_wy;

  // Block state.
  logic [TIME_W-1:0]        time_now;
  logic [COORD_BITS-1:0]    last_x;
  logic [COORD_BITS-1:0]    last_y;
  logic [SCROLL_W-1:0]      acc_x;
  logic [SCROLL_W-1:0]      acc_y;

  logic                     out_valid;
  logic                     s_fire;
  logic                     frame_fire;
  logic [TIME_W-1:0]        time_next;
  lane_stat_t               stat [BUTTONS];
  logic [BUTTONS-1:0]       down_m;
  logic [BUTTONS-1:0]       up_m;
  logic [BUTTONS-1:0]       dbl_m;
  logic [BUTTONS-1:0]       drag_m;

  mcdq_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // A wheel request never needs the output register.
  assign s_fire     = s_valid & ((s_type == REQ_WHEEL) | ~out_valid | rsp.ready);
  assign frame_fire = s_fire & (s_type == REQ_FRAME);
  assign req.ready  = ~s_valid | s_fire;
  assign time_next  = time_now + TIME_W'(s_ticks);

  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    mcdq_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .fire      (frame_fire),
      .btn       (s_btn[b]),
      .time_next (time_next),
      .px        (s_px),
      .py        (s_py),
      .regs      (regs),
      .stat      (stat[b])
    );
    assign down_m[b] = stat[b].down;
    assign up_m[b]   = stat[b].up;
    assign dbl_m[b]  = stat[b].dbl;
    assign drag_m[b] = stat[b].drag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s_type  <= req.req_type;
      s_btn   <= req.button_mask;
      s_px    <= req.pos_x;
      s_py    <= req.pos_y;
      s_ticks <= req.frame_ticks;
      s_wx    <= req.wheel_x;
      s_wy    <= req.wheel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      last_x   <= '0;
      last_y   <= '0;
      acc_x    <= '0;
      acc_y    <= '0;
    end else if (s_fire) begin
      if (s_type == REQ_WHEEL) begin
        acc_x <= sat_add(acc_x, s_wx);
        acc_y <= sat_add(acc_y, s_wy);
      end else begin
        time_now <= time_next;
        last_x   <= s_px;
        last_y   <= s_py;
        acc_x    <= '0;
        acc_y    <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_fire) begin
      rsp.pressed_mask <= s_btn;
      rsp.down_mask    <= down_m;
      rsp.up_mask      <= up_m;
      rsp.double_mask  <= dbl_m;
      rsp.drag_mask    <= drag_m;
      rsp.delta_x      <= $signed({s_px[COORD_BITS-1], s_px}) -
                          $signed({last_x[COORD_BITS-1], last_x});
      rsp.delta_y      <= $signed({s_py[COORD_BITS-1], s_py}) -
                          $signed({last_y[COORD_BITS-1], last_y});
      rsp.scroll_x     <= acc_x;
      rsp.scroll_y     <= acc_y;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// File: tb/sv/mcdq_frame_checker.sv
`timescale 1ns / 1ps
// Frame report checker: tracks buttons, clicks, drags and scroll, and compares each report.
module mcdq_frame_checker (
  input  logic clk,
  input  logic rst,
  mcdq_req_if  req_ch,
  mcdq_rsp_if  rsp_ch,
  mcdq_cfg_if  cfg_ch,
  output int   mismatches,
  output int   frames_due
);
  import mcdq_pkg::*;

  localparam int NB = BUTTONS_DEF;
  localparam int NC = COORD_BITS_DEF;
  localparam int SCROLL_MAX = 2 ** (SCROLL_W - 1) - 1;
  localparam int SCROLL_MIN = -(2 ** (SCROLL_W - 1));

  typedef struct packed {
    logic [NB-1:0]              pressed;
    logic [NB-1:0]              down;
    logic [NB-1:0]              up;
    logic [NB-1:0]              dbl;
    logic [NB-1:0]              drag;
    logic signed [NC:0]         dx;
    logic signed [NC:0]         dy;
    logic signed [SCROLL_W-1:0] sx;
    logic signed [SCROLL_W-1:0] sy;
  } frame_report_t;

  logic [WINDOW_W-1:0]        window_ticks;
  logic [DRAG_W-1:0]          drag_px;
  logic [TIME_W-1:0]          tick_count;
  logic [NB-1:0]              held_before;
  logic [NB-1:0]              dragging;
  logic [TIME_W-1:0]          click_time [NB];
  logic                       click_armed [NB];
  logic signed [NC-1:0]       anchor_x [NB];
  logic signed [NC-1:0]       anchor_y [NB];
  logic signed [NC-1:0]       prev_x;
  logic signed [NC-1:0]       prev_y;
  logic signed [SCROLL_W-1:0] scroll_x_acc;
  logic signed [SCROLL_W-1:0] scroll_y_acc;

  frame_report_t frame_reports_q[$];
  int err_n = 0;
  int reports_seen = 0;

  task automatic clear_tracking();
    window_ticks = WINDOW_RESET;
    drag_px      = DRAG_W'(DRAG_RESET);
    tick_count   = '0;
    held_before  = '0;
    dragging     = '0;
    prev_x       = '0;
    prev_y       = '0;
    scroll_x_acc = '0;
    scroll_y_acc = '0;
    for (int b = 0; b < NB; b++) begin
      click_time[b]  = '0;
      click_armed[b] = 1'b0;
      anchor_x[b]    = '0;
      anchor_y[b]    = '0;
    end
  endtask

  task automatic report(input string what);
    err_n++;
    if (err_n <= 40) $display("%0t: %s", $time, what);
  endtask

  task automatic field_check(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("report %0d: %s is %0h, expected %0h", reports_seen, name, got, want));
  endtask

  function automatic logic signed [SCROLL_W-1:0] add_scroll(
    input logic signed [SCROLL_W-1:0] acc, input logic signed [WHEEL_W-1:0] steps);
    int sum;
    sum = int'(acc) + int'(steps);
    if (sum > SCROLL_MAX) sum = SCROLL_MAX;
    else if (sum < SCROLL_MIN) sum = SCROLL_MIN;
    return SCROLL_W'(sum);
  endfunction

  // Advances the tick count first, so a down edge is timed against the new count.
  function automatic frame_report_t qualify_frame(input logic [NB-1:0] held,
                                                  input logic signed [NC-1:0] px,
                                                  input logic signed [NC-1:0] py,
                                                  input logic [TICK_W-1:0] ticks);
    frame_report_t r;
    logic [NB-1:0] down;
    logic [NB-1:0] up;
    logic [TIME_W-1:0] since;
    longint ex, ey, thr2;
    r = '0;
    tick_count = tick_count + TIME_W'(ticks);
    down = held & ~held_before;
    up   = ~held & held_before;
    thr2 = longint'(drag_px) * longint'(drag_px);
    for (int b = 0; b < NB; b++) begin
      if (down[b]) begin
        since = tick_count - click_time[b];
        if (click_armed[b] && since <= TIME_W'(window_ticks)) begin
          r.dbl[b] = 1'b1;
          click_armed[b] = 1'b0;
        end else begin
          click_time[b]  = tick_count;
          click_armed[b] = 1'b1;
        end
        anchor_x[b] = px;
        anchor_y[b] = py;
      end
      if (held[b]) begin
        if (!dragging[b]) begin
          ex = longint'(px) - longint'(anchor_x[b]);
          ey = longint'(py) - longint'(anchor_y[b]);
          if (ex * ex + ey * ey >= thr2) dragging[b] = 1'b1;
        end
      end else if (up[b]) begin
        dragging[b] = 1'b0;
      end
    end
    r.pressed = held;
    r.down    = down;
    r.up      = up;
    r.drag    = dragging;
    r.dx      = (NC + 1)'(longint'(px) - longint'(prev_x));
    r.dy      = (NC + 1)'(longint'(py) - longint'(prev_y));
    r.sx      = scroll_x_acc;
    r.sy      = scroll_y_acc;
    prev_x       = px;
    prev_y       = py;
    held_before  = held;
    scroll_x_acc = '0;
    scroll_y_acc = '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    frame_report_t want;
    if (rst) begin
      clear_tracking();
      frame_reports_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_WINDOW: window_ticks = cfg_ch.data[WINDOW_W-1:0];
          REG_DRAG:   drag_px = cfg_ch.data[DRAG_W-1:0];
          default:    ;
        endcase
      end
      // Results are taken before requests: a result leaving now belongs to an older request.
      if (rsp_ch.valid && rsp_ch.ready) begin
        reports_seen++;
        if (frame_reports_q.size() == 0) begin
          report($sformatf("report %0d arrived with no frame outstanding", reports_seen));
        end else begin
          want = frame_reports_q.pop_front();
          field_check("pressed_mask", 32'(rsp_ch.pressed_mask), 32'(want.pressed));
          field_check("down_mask", 32'(rsp_ch.down_mask), 32'(want.down));
          field_check("up_mask", 32'(rsp_ch.up_mask), 32'(want.up));
          field_check("double_mask", 32'(rsp_ch.double_mask), 32'(want.dbl));
          field_check("drag_mask", 32'(rsp_ch.drag_mask), 32'(want.drag));
          field_check("delta_x", 32'(rsp_ch.delta_x), 32'(want.dx));
          field_check("delta_y", 32'(rsp_ch.delta_y), 32'(want.dy));
          field_check("scroll_x", 32'(rsp_ch.scroll_x), 32'(want.sx));
          field_check("scroll_y", 32'(rsp_ch.scroll_y), 32'(want.sy));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.req_type == REQ_WHEEL) begin
          scroll_x_acc = add_scroll(scroll_x_acc, req_ch.wheel_x);
          scroll_y_acc = add_scroll(scroll_y_acc, req_ch.wheel_y);
        end else begin
          frame_reports_q.push_back(qualify_frame(req_ch.button_mask, req_ch.pos_x,
                                                  req_ch.pos_y, req_ch.frame_ticks));
        end
      end
    end
    frames_due <= frame_reports_q.size();
    mismatches <= err_n;
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the click and drag qualifier testbench: clock, reset, requests and verdict.
module tb;
  import mcdq_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_DRAG + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;
  localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = 8'sh7F;
  localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = 8'sh80;
  localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [15:0] COORD_MIN = 16'sh8000;

  logic clk;
  logic rst;
  int   mismatches;
  int   frames_due;

  mcdq_req_if req_ch ();
  mcdq_rsp_if rsp_ch ();
  mcdq_cfg_if cfg_ch ();

  mouse_click_drag_qualifier_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  mcdq_frame_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req_ch     (req_ch),
    .rsp_ch     (rsp_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .frames_due (frames_due)
  );

  logic [4:0]          cur_mask;
  int                  cur_x;
  int                  cur_y;
  logic [WINDOW_W-1:0] cfg_window;
  logic [DRAG_W-1:0]   cfg_drag;
  int                  burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: stall modes are picked at random, one of them never stalls.
  initial begin
    int mode_left, mode, stall_run;
    mode_left = 0;
    mode = 0;
    stall_run = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        2: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_run > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_run--;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  task automatic drive_request(input logic kind, input logic [4:0] mask,
                               input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic [TICK_W-1:0] ticks,
                               input logic signed [WHEEL_W-1:0] wx,
                               input logic signed [WHEEL_W-1:0] wy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.button_mask <= mask;
    req_ch.pos_x       <= x;
    req_ch.pos_y       <= y;
    req_ch.frame_ticks <= ticks;
    req_ch.wheel_x     <= wx;
    req_ch.wheel_y     <= wy;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // The wheel fields of a frame request carry noise.
  task automatic send_frame(input logic [4:0] mask, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic [TICK_W-1:0] ticks);
    cur_mask = mask;
    cur_x = int'(x);
    cur_y = int'(y);
    drive_request(REQ_FRAME, mask, x, y, ticks, WHEEL_W'($urandom), WHEEL_W'($urandom));
  endtask

  task automatic send_wheel(input logic signed [WHEEL_W-1:0] wx,
                            input logic signed [WHEEL_W-1:0] wy);
    drive_request(REQ_WHEEL, 5'($urandom), 16'($urandom), 16'($urandom),
                  TICK_W'($urandom), wx, wy);
  endtask

  // Waits until every frame has reported, then leaves room for a wheel request in flight.
  task automatic settle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (frames_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] window,
                              input logic [CFG_DATA_W-1:0] drag);
    settle();
    write_reg(REG_WINDOW, window);
    write_reg(REG_DRAG, drag);
    write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
              CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    cfg_window = window[WINDOW_W-1:0];
    cfg_drag   = drag[DRAG_W-1:0];
  endtask

  // Mostly single-button toggles, short tick gaps and small moves, so that double
  // clicks and drags come up often; now and then a jump anywhere.
  task automatic random_traffic(input int n);
    logic [4:0] m;
    logic [TICK_W-1:0] tk;
    int lim, step, nx, ny;
    repeat (n) begin
      if ($urandom_range(0, 99) < 12) begin
        send_wheel(WHEEL_W'($urandom), WHEEL_W'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:             m = 5'($urandom);
          1, 2, 3, 4, 5, 6: m = cur_mask ^ (5'b1 << $urandom_range(0, 4));
          default:       m = cur_mask;
        endcase
        lim = int'(cfg_window) / 2 + 2;
        if (lim > 65535) lim = 65535;
        case ($urandom_range(0, 9))
          0:       tk = '0;
          1:       tk = TICK_W'($urandom);
          default: tk = TICK_W'($urandom_range(0, lim));
        endcase
        case ($urandom_range(0, 19))
          0: begin
            nx = int'($urandom_range(0, 65535)) - 32768;
            ny = int'($urandom_range(0, 65535)) - 32768;
          end
          1: begin
            nx = $urandom_range(0, 1) ? int'(COORD_MAX) : int'(COORD_MIN);
            ny = $urandom_range(0, 1) ? int'(COORD_MAX) : int'(COORD_MIN);
          end
          default: begin
            step = int'(cfg_drag) / 2 + 2;
            nx = cur_x + int'($urandom_range(0, 2 * step)) - step;
            ny = cur_y + int'($urandom_range(0, 2 * step)) - step;
            nx = (nx > COORD_MAX) ? int'(COORD_MAX) : ((nx < COORD_MIN) ? int'(COORD_MIN) : nx);
            ny = (ny > COORD_MAX) ? int'(COORD_MAX) : ((ny < COORD_MIN) ? int'(COORD_MIN) : ny);
          end
        endcase
        send_frame(m, 16'(nx), 16'(ny), tk);
      end
    end
  endtask

  // Drives both scroll accumulators into saturation, then backs off a few steps.
  task automatic wheel_storm(input bit upward);
    repeat ($urandom_range(260, 280)) begin
      if (upward) send_wheel(WHEEL_MAX, WHEEL_MIN);
      else send_wheel(WHEEL_MIN, WHEEL_MAX);
    end
    repeat (5) begin
      if (upward) send_wheel(-8'sd3, 8'sd3);
      else send_wheel(8'sd3, -8'sd3);
    end
    send_frame(cur_mask, 16'(cur_x), 16'(cur_y), 16'd1);
    send_frame(cur_mask, 16'(cur_x), 16'(cur_y), 16'd1);
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_FRAME;
    req_ch.button_mask <= '0;
    req_ch.pos_x       <= '0;
    req_ch.pos_y       <= '0;
    req_ch.frame_ticks <= '0;
    req_ch.wheel_x     <= '0;
    req_ch.wheel_y     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    cur_mask   = '0;
    cur_x      = 0;
    cur_y      = 0;
    cfg_window = WINDOW_RESET;
    cfg_drag   = DRAG_W'(DRAG_RESET);
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the registers as reset leaves them.
    send_frame(5'b00000, 16'sd0, 16'sd0, 16'd0);
    send_wheel(WHEEL_MAX, WHEEL_MIN);
    send_wheel(-8'sd1, 8'sd1);
    send_frame(5'b11111, COORD_MAX, COORD_MIN, 16'hFFFF);
    send_frame(5'b00000, COORD_MIN, COORD_MAX, 16'd10);
    send_frame(5'b11111, COORD_MIN, COORD_MAX, 16'd10);
    send_frame(5'b11111, COORD_MIN + 16'sd3, COORD_MAX, 16'd1);
    send_frame(5'b11111, COORD_MIN, COORD_MAX - 16'sd4, 16'd1);
    send_frame(5'b11111, COORD_MIN, COORD_MAX, 16'd1);
    send_frame(5'b10101, COORD_MIN, COORD_MAX, 16'd1);
    send_frame(5'b00000, 16'sd0, 16'sd0, 16'd3);
    send_frame(5'b00001, 16'sd0, 16'sd0, 16'd500);
    send_frame(5'b00000, 16'sd0, 16'sd0, 16'd0);
    send_frame(5'b00001, 16'sd0, 16'sd0, 16'd500);
    send_frame(5'b00000, 16'sd0, 16'sd0, 16'd0);
    send_frame(5'b00001, 16'sd0, 16'sd0, 16'd0);
    send_frame(5'b00000, 16'sd0, 16'sd0, 16'd200);
    send_frame(5'b00001, 16'sd0, 16'sd0, 16'd301);
    send_frame(5'b00001, 16'sd3, 16'sd2, 16'd0);
    send_wheel(WHEEL_MAX, WHEEL_MAX);
    send_frame(5'b00000, 16'sd3, 16'sd2, 16'd0);

    program_regs(16'd0, 16'd0);
    random_traffic(300);
    program_regs(16'hFFFF, 16'hFFFF);
    random_traffic(300);
    program_regs(16'($urandom), {4'($urandom), 12'($urandom_range(0, 40))});
    wheel_storm(1'b1);
    random_traffic(20);
    wheel_storm(1'b0);
    program_regs(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 40)));
    random_traffic(400);
    program_regs(16'($urandom), 16'($urandom));
    random_traffic(200);
    program_regs(16'd1000, 16'd4);
    random_traffic(40);
    settle();
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
